FILE: src/mtdp_pkg.sv
package mtdp_pkg;

  localparam int TextCapacity = 256;
  localparam logic [7:0] LenLimit = 8'(TextCapacity - 1);

  localparam int QueueDepth = 2;
  localparam int QueuePtrW = $clog2(QueueDepth);
  localparam int QueueCntW = $clog2(QueueDepth + 1);

  typedef enum logic [2:0] {
    OP_UP      = 3'd0,
    OP_DOWN    = 3'd1,
    OP_LEFT    = 3'd2,
    OP_RIGHT   = 3'd3,
    OP_SELECT  = 3'd4,
    OP_BACK    = 3'd5,
    OP_BUTTONS = 3'd6,
    OP_TYPED   = 3'd7
  } op_e;

  localparam logic [3:0] KeyGroupEnd = 4'd9;
  localparam logic [3:0] KeyDelete   = 4'd9;
  localparam logic [3:0] KeySpace    = 4'd10;
  localparam logic [3:0] KeySave     = 4'd11;

  typedef struct packed {
    logic [3:0] cursor;
    logic [6:0] pending_char;
    logic [7:0] text_length;
    logic       c0_valid;
    logic [7:0] c0_index;
    logic [6:0] c0_char;
    logic       two_commits;
    logic [7:0] c1_index;
    logic [6:0] c1_char;
    logic       removed;
    logic       save_request;
  } rec_t;

endpackage

FILE: src/mtdp_front.sv
module mtdp_front import mtdp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] operation_i,
  input  logic [6:0] key_char_i,
  input  logic       button_delete_i,
  input  logic       button_save_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output rec_t       q_data_o
);

  logic [3:0] cur_q, cur_d;
  logic [6:0] pend_q, pend_d;
  logic [7:0] len_q, len_d;

  logic       del_req, pre_set, req1, req2, set_mid, sav, rem, ok1, ok2, typed_ok;
  logic [6:0] mid_char, lo, hi;
  rec_t       rec;

  function automatic logic [6:0] group_lo(input logic [3:0] k);
    logic [6:0] r;
    unique case (k)
      4'd0:    r = 7'h30;
      4'd1:    r = 7'h41;
      4'd2:    r = 7'h44;
      4'd3:    r = 7'h47;
      4'd4:    r = 7'h4a;
      4'd5:    r = 7'h4d;
      4'd6:    r = 7'h50;
      4'd7:    r = 7'h54;
      4'd8:    r = 7'h57;
      default: r = 7'h30;
    endcase
    return r;
  endfunction

  function automatic logic [6:0] group_hi(input logic [3:0] k);
    logic [6:0] r;
    unique case (k)
      4'd0:    r = 7'h39;
      4'd1:    r = 7'h43;
      4'd2:    r = 7'h46;
      4'd3:    r = 7'h49;
      4'd4:    r = 7'h4c;
      4'd5:    r = 7'h4f;
      4'd6:    r = 7'h53;
      4'd7:    r = 7'h56;
      4'd8:    r = 7'h5a;
      default: r = 7'h39;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] col_of(input logic [3:0] c);
    logic [1:0] r;
    unique case (c)
      4'd0, 4'd3, 4'd6, 4'd9:   r = 2'd0;
      4'd1, 4'd4, 4'd7, 4'd10:  r = 2'd1;
      4'd2, 4'd5, 4'd8, 4'd11:  r = 2'd2;
      default:                  r = 2'd0;
    endcase
    return r;
  endfunction

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && in_ready_o;
  assign q_data_o   = rec;

  assign lo = group_lo(cur_q);
  assign hi = group_hi(cur_q);
  assign typed_ok = (key_char_i >= 7'h41 && key_char_i <= 7'h5a) ||
                    (key_char_i >= 7'h30 && key_char_i <= 7'h39) ||
                    (key_char_i == 7'h20);

  always_comb begin
    cur_d    = cur_q;
    pend_d   = pend_q;
    len_d    = len_q;
    del_req  = 1'b0;
    pre_set  = 1'b0;
    req1     = 1'b0;
    req2     = 1'b0;
    set_mid  = 1'b0;
    mid_char = '0;
    sav      = 1'b0;
    rem      = 1'b0;
    rec      = '0;

    unique case (op_e'(operation_i))
      OP_UP: begin
        req1  = 1'b1;
        cur_d = (cur_q < 4'd3) ? cur_q + 4'd9 : cur_q - 4'd3;
      end
      OP_DOWN: begin
        req1  = 1'b1;
        cur_d = (cur_q > 4'd8) ? cur_q - 4'd9 : cur_q + 4'd3;
      end
      OP_LEFT: begin
        req1  = 1'b1;
        cur_d = (col_of(cur_q) == 2'd0) ? cur_q + 4'd2 : cur_q - 4'd1;
      end
      OP_RIGHT: begin
        req1  = 1'b1;
        cur_d = (col_of(cur_q) == 2'd2) ? cur_q - 4'd2 : cur_q + 4'd1;
      end
      OP_SELECT: begin
        priority if (cur_q < KeyGroupEnd) begin
          set_mid = 1'b1;
          if (pend_q < lo || pend_q > hi) begin
            req1     = 1'b1;
            mid_char = lo;
          end else begin
            mid_char = (pend_q == hi) ? lo : pend_q + 7'd1;
          end
        end else if (cur_q == KeyDelete) begin
          del_req = 1'b1;
        end else if (cur_q == KeySpace) begin
          req1     = 1'b1;
          set_mid  = 1'b1;
          mid_char = 7'h20;
          req2     = 1'b1;
        end else if (cur_q == KeySave) begin
          req1 = 1'b1;
          sav  = 1'b1;
        end
      end
      OP_BACK: del_req = 1'b1;
      OP_BUTTONS: begin
        del_req = button_delete_i;
        req1    = button_save_i;
        sav     = button_save_i;
      end
      OP_TYPED: begin
        pre_set = typed_ok;
        req1    = typed_ok;
      end
      default: ;
    endcase

    if (del_req) begin
      if (pend_d != '0) begin
        pend_d = '0;
      end else if (len_d != '0) begin
        len_d = len_d - 8'd1;
        rem   = 1'b1;
      end
    end
    if (pre_set) begin
      pend_d = key_char_i;
    end

    ok1 = req1 && (len_d < LenLimit) && (pend_d != '0);
    if (ok1) begin
      rec.c0_valid = 1'b1;
      rec.c0_index = len_d;
      rec.c0_char  = pend_d;
      len_d        = len_d + 8'd1;
      pend_d       = '0;
    end
    if (set_mid) begin
      pend_d = mid_char;
    end

    ok2 = req2 && (len_d < LenLimit) && (pend_d != '0);
    if (ok2) begin
      if (ok1) begin
        rec.two_commits = 1'b1;
        rec.c1_index    = len_d;
        rec.c1_char     = pend_d;
      end else begin
        rec.c0_valid = 1'b1;
        rec.c0_index = len_d;
        rec.c0_char  = pend_d;
      end
      len_d  = len_d + 8'd1;
      pend_d = '0;
    end

    rec.cursor       = cur_d;
    rec.pending_char = pend_d;
    rec.text_length  = len_d;
    rec.removed      = rem;
    rec.save_request = sav;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q  <= '0;
      pend_q <= '0;
      len_q  <= '0;
    end else if (q_push_o) begin
      cur_q  <= cur_d;
      pend_q <= pend_d;
      len_q  <= len_d;
    end
  end

endmodule

FILE: src/mtdp_queue.sv
module mtdp_queue import mtdp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  rec_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output rec_t head_o
);

  rec_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] cnt_q;

  assign full_o  = (cnt_q == QueueCntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

FILE: src/mtdp_back.sv
module mtdp_back import mtdp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_empty_i,
  input  rec_t       q_head_i,
  output logic       q_pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [3:0] cursor_o,
  output logic [6:0] pending_char_o,
  output logic [7:0] text_length_o,
  output logic       commit_valid_o,
  output logic [7:0] commit_index_o,
  output logic [6:0] commit_char_o,
  output logic       removed_o,
  output logic       save_request_o,
  output logic       last_o
);

  rec_t rec_q;
  logic busy_q, phase_q;
  logic xfer;

  assign out_valid_o    = busy_q;
  assign last_o         = phase_q || !rec_q.two_commits;
  assign xfer           = busy_q && out_ready_i;
  assign q_pop_o        = !q_empty_i && (!busy_q || (xfer && last_o));

  assign cursor_o       = rec_q.cursor;
  assign pending_char_o = rec_q.pending_char;
  assign text_length_o  = rec_q.text_length;
  assign commit_valid_o = phase_q || rec_q.c0_valid;
  assign commit_index_o = phase_q ? rec_q.c1_index : rec_q.c0_index;
  assign commit_char_o  = phase_q ? rec_q.c1_char : rec_q.c0_char;
  assign removed_o      = last_o && rec_q.removed;
  assign save_request_o = last_o && rec_q.save_request;

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      rec_q <= q_head_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= 1'b0;
    end else if (q_pop_o) begin
      busy_q  <= 1'b1;
      phase_q <= 1'b0;
    end else if (xfer) begin
      if (last_o) begin
        busy_q  <= 1'b0;
        phase_q <= 1'b0;
      end else begin
        phase_q <= 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_phase_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> busy_q && rec_q.two_commits)
    else $error("second result shown without a two-commit record");

  a_two_has_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && rec_q.two_commits |-> rec_q.c0_valid)
    else $error("two-commit record without a first commit");

  a_first_then_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer && !last_o |=> busy_q && phase_q)
    else $error("second result lost after first transfer");

  a_no_pop_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !phase_q && rec_q.two_commits |-> !q_pop_o)
    else $error("record replaced before its second result");
`endif

endmodule

FILE: src/multi_tap_dial_pad_entry_top.sv
// multi-tap text entry on a 4x3 dial pad: a front end accepts one item per cycle while the
// queue has room, updates cursor, pending character and text length at once and places a
// result record in a two-entry queue; a back end holds the record in the output register
// and presents one result per cycle while the output is taken, two for an item that
// commits twice. an item's first result passes through its queue entry and then the output
// register; the output stage sets the sustained rate at one result per cycle while the
// output is taken, so an item yields one or two results
module multi_tap_dial_pad_entry_top import mtdp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] operation_i,
  input  logic [6:0] key_char_i,
  input  logic       button_delete_i,
  input  logic       button_save_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [3:0] cursor_o,
  output logic [6:0] pending_char_o,
  output logic [7:0] text_length_o,
  output logic       commit_valid_o,
  output logic [7:0] commit_index_o,
  output logic [6:0] commit_char_o,
  output logic       removed_o,
  output logic       save_request_o,
  output logic       last_o
);

  logic q_push, q_full, q_pop, q_empty;
  rec_t q_data, q_head;

  mtdp_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .key_char_i     (key_char_i),
    .button_delete_i(button_delete_i),
    .button_save_i  (button_save_i),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_data_o       (q_data)
  );

  mtdp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_data),
    .full_o (q_full),
    .pop_i  (q_pop),
    .empty_o(q_empty),
    .head_o (q_head)
  );

  mtdp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_head_i      (q_head),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .cursor_o      (cursor_o),
    .pending_char_o(pending_char_o),
    .text_length_o (text_length_o),
    .commit_valid_o(commit_valid_o),
    .commit_index_o(commit_index_o),
    .commit_char_o (commit_char_o),
    .removed_o     (removed_o),
    .save_request_o(save_request_o),
    .last_o        (last_o)
  );

endmodule
